>>> hw/rtl/tccw_pkg.sv
// ----------------------------------------------------------------------------
// tccw_pkg: shared definitions for the text console character writer
// Screen geometry, command codes, queue entry format and back end states.
// ----------------------------------------------------------------------------
`default_nettype none

package tccw_pkg;

   // Screen geometry
   localparam int COLUMNS       = 80;
   localparam int ROWS          = 25;
   localparam int CELLS         = COLUMNS * ROWS;
   localparam int MOVE_N        = CELLS - COLUMNS;
   localparam int CELL_AW       = $clog2(CELLS);
   localparam int CNT_W         = $clog2(CELLS + 1);
   localparam int COL_W         = $clog2(COLUMNS + 8);
   localparam int ROW_W         = $clog2(ROWS + 1);

   // Port field widths
   localparam int FUNC_W        = 2;
   localparam int CODE_W        = 8;
   localparam int INDEX_W       = 11;
   localparam int POS_W         = 11;
   localparam int DATA_W        = 16;
   localparam int COLOUR_W      = 4;
   localparam int CSR_IDX_W     = 2;

   // Command queue
   localparam int QUEUE_DEPTH   = 2;
   localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW      = $clog2(QUEUE_DEPTH + 1);

   // Function codes
   localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

   // Character codes
   localparam logic [CODE_W-1:0] CHAR_BS    = 8'h08;
   localparam logic [CODE_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [CODE_W-1:0] CHAR_LF    = 8'h0A;
   localparam logic [CODE_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [CODE_W-1:0] CHAR_BLANK = 8'h20;
   localparam logic [CODE_W-1:0] PRINT_LO   = 8'h20;
   localparam logic [CODE_W-1:0] PRINT_HI   = 8'h7F;

   // Tab stops every eight columns
   localparam int               TAB_STOP = 8;
   localparam logic [COL_W-1:0] TAB_MASK = ~COL_W'(TAB_STOP - 1);

   // Register indexes and reset values
   localparam logic [CSR_IDX_W-1:0] REG_FOREGROUND = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BACKGROUND = 2'd1;
   localparam logic [COLOUR_W-1:0]  FG_RESET       = 4'hF;
   localparam logic [COLOUR_W-1:0]  BG_RESET       = 4'h0;

   // Classified command
   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_BACKSPACE,
      CMD_TAB,
      CMD_CR,
      CMD_LF,
      CMD_PRINT,
      CMD_CLEAR,
      CMD_READ
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic [CODE_W-1:0]   code;
      logic [CELL_AW-1:0]  addr;
   } cmd_type;

   // Back end sequencer states
   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_READ,
      ST_MOVE,
      ST_FILL,
      ST_CLEAR
   } back_state_type;

endpackage

`default_nettype wire

>>> hw/rtl/text_console_char_writer_core.sv
// ----------------------------------------------------------------------------
// text_console_char_writer_core: text console character writer
// Put-character, clear and read commands over an 80x25 store of cell words.
// ----------------------------------------------------------------------------
// Usage:
//   A command (req_func, req_char_code, req_cell_index) transfers at a rising
//   edge with start high and busy low. It is decoded and queued (two entries),
//   and the back end executes it. Every command gives one result: rsp_valid
//   is high for one cycle with rsp_cursor_pos and rsp_cell_data; the receiver
//   cannot stall it, so results are never held.
//   With an idle back end, puts that do not scroll and no-ops pass through the
//   queue entry and the registered result, so such puts sustain one per clock
//   while the back end stays idle. A read also passes through the registered
//   memory read. Clear writes every cell, one per cycle. A put that scrolls
//   moves 1920 cells one per cycle and blanks 80. The single write port sets
//   these rates; busy is high while the queue is full or the store is being
//   zeroed after reset.
//   Colours are written through csr_valid/csr_ready (always ready), index 0
//   foreground, 1 background; write only while idle.
//   Reset: cursor homes, colours return to white on black, and the store is
//   zeroed by a pass over every cell with busy high; csr writes are taken then.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_char_writer_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire logic [tccw_pkg::FUNC_W-1:0]    req_func,
   input  wire logic [tccw_pkg::CODE_W-1:0]    req_char_code,
   input  wire logic [tccw_pkg::INDEX_W-1:0]   req_cell_index,
   output logic                                rsp_valid,
   output logic [tccw_pkg::POS_W-1:0]          rsp_cursor_pos,
   output logic [tccw_pkg::DATA_W-1:0]         rsp_cell_data,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [tccw_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [tccw_pkg::COLOUR_W-1:0]  csr_data
);
   import tccw_pkg::*;

   logic [COLOUR_W-1:0]  fg_ff, fg_in;
   logic [COLOUR_W-1:0]  bg_ff, bg_in;
   logic                 push;
   cmd_type              push_cmd;
   logic                 pop;
   cmd_type              head_cmd;
   logic                 queue_empty;
   logic                 queue_full;
   logic                 init_busy;

   // Colour registers
   assign csr_ready = 1'b1;

   always_comb begin
      fg_in = fg_ff;
      bg_in = bg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_FOREGROUND: fg_in = csr_data;
            REG_BACKGROUND: bg_in = csr_data;
            default: begin
               fg_in = fg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff <= FG_RESET;
         bg_ff <= BG_RESET;
      end else begin
         fg_ff <= fg_in;
         bg_ff <= bg_in;
      end
   end

   // Front end: intake and decode
   tccw_front u_front (
      .start          (start),
      .busy           (busy),
      .req_func       (req_func),
      .req_char_code  (req_char_code),
      .req_cell_index (req_cell_index),
      .queue_full     (queue_full),
      .init_busy      (init_busy),
      .push           (push),
      .push_cmd       (push_cmd)
   );

   // Command queue
   tccw_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .empty    (queue_empty),
      .full     (queue_full)
   );

   // Back end: execution over the cell store
   tccw_back u_back (
      .clock          (clock),
      .reset          (reset),
      .fg_colour      (fg_ff),
      .bg_colour      (bg_ff),
      .queue_empty    (queue_empty),
      .head_cmd       (head_cmd),
      .pop            (pop),
      .init_busy      (init_busy),
      .rsp_valid      (rsp_valid),
      .rsp_cursor_pos (rsp_cursor_pos),
      .rsp_cell_data  (rsp_cell_data)
   );

endmodule

`default_nettype wire

>>> hw/rtl/tccw_front.sv
// ----------------------------------------------------------------------------
// tccw_front: command intake and decode
// Takes a command when the queue has room and classifies put codes.
// ----------------------------------------------------------------------------
`default_nettype none

module tccw_front (
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [tccw_pkg::FUNC_W-1:0]   req_func,
   input  wire logic [tccw_pkg::CODE_W-1:0]   req_char_code,
   input  wire logic [tccw_pkg::INDEX_W-1:0]  req_cell_index,
   input  wire logic                          queue_full,
   input  wire logic                          init_busy,
   output logic                               push,
   output tccw_pkg::cmd_type                  push_cmd
);
   import tccw_pkg::*;

   // Hold off while the queue is full or the store is being zeroed after reset
   assign busy = queue_full | init_busy;
   assign push = start & ~busy;

   // Classify the command
   always_comb begin
      push_cmd.kind = CMD_NONE;
      push_cmd.code = req_char_code;
      push_cmd.addr = CELL_AW'(req_cell_index);
      case (req_func)
         FUNC_PUT: begin
            if (req_char_code == CHAR_BS) begin
               push_cmd.kind = CMD_BACKSPACE;
            end else if (req_char_code == CHAR_TAB) begin
               push_cmd.kind = CMD_TAB;
            end else if (req_char_code == CHAR_CR) begin
               push_cmd.kind = CMD_CR;
            end else if (req_char_code == CHAR_LF) begin
               push_cmd.kind = CMD_LF;
            end else if (req_char_code inside {[PRINT_LO:PRINT_HI]}) begin
               push_cmd.kind = CMD_PRINT;
            end
         end
         FUNC_CLEAR: begin
            push_cmd.kind = CMD_CLEAR;
         end
         FUNC_READ: begin
            // out-of-range reads return zero data, like a no-op
            if (int'(req_cell_index) < CELLS) begin
               push_cmd.kind = CMD_READ;
            end
         end
         default: begin
            push_cmd.kind = CMD_NONE;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> hw/rtl/tccw_queue.sv
// ----------------------------------------------------------------------------
// tccw_queue: command queue between front and back end
// Small FIFO of classified commands so each side can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module tccw_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire tccw_pkg::cmd_type  push_cmd,
   input  wire logic               pop,
   output tccw_pkg::cmd_type       head_cmd,
   output logic                    empty,
   output logic                    full
);
   import tccw_pkg::*;

   cmd_type                entries_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]    count_ff, count_in;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign head_cmd = entries_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   // Neither side may overrun the queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("queue transfer in while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue pop while empty");

endmodule

`default_nettype wire

>>> hw/rtl/tccw_back.sv
// ----------------------------------------------------------------------------
// tccw_back: command execution over the cell store
// Owns the cursor and the cell memory; runs put, read, clear and scroll.
// ----------------------------------------------------------------------------
`default_nettype none

module tccw_back (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [tccw_pkg::COLOUR_W-1:0]  fg_colour,
   input  wire logic [tccw_pkg::COLOUR_W-1:0]  bg_colour,
   input  wire logic                           queue_empty,
   input  wire tccw_pkg::cmd_type              head_cmd,
   output logic                                pop,
   output logic                                init_busy,
   output logic                                rsp_valid,
   output logic [tccw_pkg::POS_W-1:0]          rsp_cursor_pos,
   output logic [tccw_pkg::DATA_W-1:0]         rsp_cell_data
);
   import tccw_pkg::*;

   back_state_type         state_ff, state_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [COL_W-1:0]       col_ff, col_in;
   logic [ROW_W-1:0]       row_ff, row_in;
   logic [CELL_AW-1:0]     base_ff, base_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]       rsp_pos_ff, rsp_pos_in;
   logic [DATA_W-1:0]      rsp_data_ff, rsp_data_in;

   logic [DATA_W-1:0]      cells_mem [CELLS];
   logic [DATA_W-1:0]      rd_data_ff;
   logic [CELL_AW-1:0]     rd_addr;
   logic                   wr_en;
   logic [CELL_AW-1:0]     wr_addr;
   logic [DATA_W-1:0]      wr_data;

   logic [7:0]             attr;
   logic [DATA_W-1:0]      blank;
   logic [CELL_AW-1:0]     cur_pos;
   logic                   last_cnt;
   logic [COL_W-1:0]       put_col;
   logic                   put_adv;
   logic                   put_scroll;

   assign attr      = {bg_colour, fg_colour};
   assign blank     = {attr, CHAR_BLANK};
   assign cur_pos   = CELL_AW'(base_ff + CELL_AW'(col_ff));
   assign last_cnt  = (cnt_ff == CNT_W'(CELLS - 1));
   assign init_busy = (state_ff == ST_INIT);

   // Cursor motion of the head put command
   always_comb begin
      put_col = col_ff;
      put_adv = 1'b0;
      case (head_cmd.kind)
         CMD_BACKSPACE: begin
            if (col_ff != '0) begin
               put_col = col_ff - 1'b1;
            end
         end
         CMD_TAB: begin
            put_col = (col_ff + COL_W'(TAB_STOP)) & TAB_MASK;
         end
         CMD_CR: begin
            put_col = '0;
         end
         CMD_LF: begin
            put_col = '0;
            put_adv = 1'b1;
         end
         CMD_PRINT: begin
            put_col = col_ff + 1'b1;
         end
         default: begin
            put_col = col_ff;
         end
      endcase
      // wrap at the right edge
      if (int'(put_col) >= COLUMNS) begin
         put_col = '0;
         put_adv = 1'b1;
      end
   end

   assign put_scroll = put_adv && (row_ff == ROW_W'(ROWS - 1));

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (last_cnt) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!queue_empty) begin
               case (head_cmd.kind)
                  CMD_CLEAR: state_in = ST_CLEAR;
                  CMD_READ:  state_in = ST_READ;
                  default:   state_in = put_scroll ? ST_MOVE : ST_IDLE;
               endcase
            end
         end
         ST_READ: begin
            state_in = ST_IDLE;
         end
         ST_MOVE: begin
            if (cnt_ff == CNT_W'(MOVE_N)) begin
               state_in = ST_FILL;
            end
         end
         ST_FILL, ST_CLEAR: begin
            if (last_cnt) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath, memory ports and result
   always_comb begin
      cnt_in       = cnt_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      base_in      = base_ff;
      pop          = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = CELL_AW'(cnt_ff);
      wr_data      = blank;
      rd_addr      = CELL_AW'(cnt_ff + CNT_W'(COLUMNS));
      rsp_valid_in = 1'b0;
      rsp_pos_in   = POS_W'(cur_pos);
      rsp_data_in  = '0;
      case (state_ff)
         ST_INIT: begin
            wr_en   = 1'b1;
            wr_data = '0;
            cnt_in  = last_cnt ? '0 : cnt_ff + 1'b1;
         end
         ST_IDLE: begin
            if (!queue_empty) begin
               pop = 1'b1;
               case (head_cmd.kind)
                  CMD_CLEAR: begin
                     cnt_in  = '0;
                     col_in  = '0;
                     row_in  = '0;
                     base_in = '0;
                  end
                  CMD_READ: begin
                     rd_addr = head_cmd.addr;
                  end
                  default: begin
                     if (head_cmd.kind == CMD_PRINT) begin
                        wr_en   = 1'b1;
                        wr_addr = cur_pos;
                        wr_data = {attr, head_cmd.code};
                     end
                     col_in = put_col;
                     // on the last row the row stays put and the screen scrolls
                     if (put_adv && !put_scroll) begin
                        row_in  = row_ff + 1'b1;
                        base_in = CELL_AW'(base_ff + CELL_AW'(COLUMNS));
                     end
                     if (put_scroll) begin
                        cnt_in = '0;
                     end else begin
                        rsp_valid_in = 1'b1;
                        rsp_pos_in   = POS_W'(CELL_AW'(base_in + CELL_AW'(col_in)));
                     end
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = rd_data_ff;
         end
         ST_MOVE: begin
            // read one row ahead, write back the word read last cycle
            wr_en   = (cnt_ff != '0);
            wr_addr = CELL_AW'(cnt_ff - 1'b1);
            wr_data = rd_data_ff;
            if (cnt_ff != CNT_W'(MOVE_N)) begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_FILL, ST_CLEAR: begin
            wr_en = 1'b1;
            if (last_cnt) begin
               rsp_valid_in = 1'b1;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cnt_ff       <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         base_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         base_ff      <= base_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      rsp_pos_ff  <= rsp_pos_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Cell store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         cells_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= cells_mem[rd_addr];
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cursor_pos = rsp_pos_ff;
   assign rsp_cell_data  = rsp_data_ff;

   // Cursor stays on screen and the row base tracks the row
   a_row_range: assert property (@(posedge clock) disable iff (reset)
      int'(row_ff) < ROWS)
      else $error("cursor row off screen");
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      int'(col_ff) < COLUMNS)
      else $error("cursor column off screen");
   a_base_match: assert property (@(posedge clock) disable iff (reset)
      int'(base_ff) == int'(row_ff) * COLUMNS)
      else $error("row base out of step with cursor row");

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for text_console_char_writer_core
// Directed commands, then phases of random console traffic (text lines,
// line feeds, editing codes, reads, noise, clears) under several colour
// settings. A shadow of the screen store and cursor predicts each reply,
// and every strobed reply is compared with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
   import tccw_pkg::*;

   // Unused function code: no operation
   localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;

   localparam int INDEX_MAX     = (1 << INDEX_W) - 1;
   localparam int CODE_MAX      = (1 << CODE_W) - 1;
   localparam int PHASES        = 5;
   localparam int PHASE_ITEMS   = 240;
   // Worst case: every command a full-store pass plus its longest gap, 4x over
   localparam int TIMEOUT_CYCLES = (PHASES * PHASE_ITEMS + 200) * (CELLS + 16) * 4;
   // Idle cycles before a colour write, and after the last reply
   localparam int SETTLE_CYCLES = 8;
   localparam int END_CYCLES    = CELLS + 100;

   typedef struct packed {
      logic [POS_W-1:0]  pos;
      logic [DATA_W-1:0] data;
   } cursor_cell_type;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [CODE_W-1:0]  code;
      logic [INDEX_W-1:0] idx;
      logic               pinned;
      logic [POS_W-1:0]   pos;
      logic [DATA_W-1:0]  data;
   } directed_step_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [FUNC_W-1:0]    req_func = '0;
   logic [CODE_W-1:0]    req_char_code = '0;
   logic [INDEX_W-1:0]   req_cell_index = '0;
   logic                 rsp_valid;
   logic [POS_W-1:0]     rsp_cursor_pos;
   logic [DATA_W-1:0]    rsp_cell_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [COLOUR_W-1:0]  csr_data = '0;

   // Typed-in reply for a directed row, driven alongside the command
   logic                 pin_valid = 1'b0;
   logic [POS_W-1:0]     pin_pos = '0;
   logic [DATA_W-1:0]    pin_data = '0;

   // Shadow of the console state
   logic [DATA_W-1:0]    shadow_cells [CELLS];
   int                   shadow_col = 0;
   int                   shadow_row = 0;
   logic [COLOUR_W-1:0]  shadow_fg = FG_RESET;
   logic [COLOUR_W-1:0]  shadow_bg = BG_RESET;

   cursor_cell_type      pending_cursor_cells [$];
   directed_step_type    directed_plan [$];
   int unsigned          cmds_sent = 0;
   int unsigned          replies_seen = 0;
   int unsigned          error_count = 0;
   int unsigned          cycle_count = 0;
   bit                   idle_enable = 1'b0;

   text_console_char_writer_core dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_func       (req_func),
      .req_char_code  (req_char_code),
      .req_cell_index (req_cell_index),
      .rsp_valid      (rsp_valid),
      .rsp_cursor_pos (rsp_cursor_pos),
      .rsp_cell_data  (rsp_cell_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Advance the shadow console by one command and return its reply
   function automatic cursor_cell_type apply_console_cmd(input logic [FUNC_W-1:0] f,
                                                         input logic [CODE_W-1:0] c,
                                                         input logic [INDEX_W-1:0] idx);
      cursor_cell_type   r;
      logic [DATA_W-1:0] blank;
      int                slot;
      blank  = {shadow_bg, shadow_fg, CHAR_BLANK};
      r.data = '0;
      case (f)
         FUNC_PUT: begin
            if (c == CHAR_BS) begin
               if (shadow_col != 0) shadow_col--;
            end else if (c == CHAR_TAB) begin
               shadow_col = (shadow_col + TAB_STOP) & ~(TAB_STOP - 1);
            end else if (c == CHAR_CR) begin
               shadow_col = 0;
            end else if (c == CHAR_LF) begin
               shadow_col = 0;
               shadow_row++;
            end else if (c >= PRINT_LO && c <= PRINT_HI) begin
               slot = shadow_row * COLUMNS + shadow_col;
               if (slot < CELLS) shadow_cells[slot] = {shadow_bg, shadow_fg, c};
               shadow_col++;
            end
            // column wrap, then scroll past the last row
            if (shadow_col >= COLUMNS) begin
               shadow_col = 0;
               shadow_row++;
            end
            if (shadow_row >= ROWS) begin
               for (slot = 0; slot < CELLS - COLUMNS; slot++)
                  shadow_cells[slot] = shadow_cells[slot + COLUMNS];
               for (slot = CELLS - COLUMNS; slot < CELLS; slot++)
                  shadow_cells[slot] = blank;
               shadow_row = ROWS - 1;
            end
         end
         FUNC_CLEAR: begin
            for (slot = 0; slot < CELLS; slot++) shadow_cells[slot] = blank;
            shadow_col = 0;
            shadow_row = 0;
         end
         FUNC_READ: begin
            if (idx < CELLS) r.data = shadow_cells[idx];
         end
         default: ;
      endcase
      r.pos = POS_W'(shadow_row * COLUMNS + shadow_col);
      return r;
   endfunction

   // Reply check, colour tracking and prediction, all on pre-edge values
   always @(posedge clock) begin : monitor
      cursor_cell_type want;
      cursor_cell_type got;
      if (!reset) begin
         if (rsp_valid === 1'b1) begin
            replies_seen++;
            got = '{pos: rsp_cursor_pos, data: rsp_cell_data};
            if (pending_cursor_cells.size() == 0) begin
               error_count++;
               $display("%0t reply with none pending: expected nothing, actual pos %0d data %h",
                        $time, got.pos, got.data);
            end else begin
               want = pending_cursor_cells.pop_front();
               if (got.pos !== want.pos) begin
                  error_count++;
                  $display("%0t cursor_pos mismatch: expected %0d actual %0d",
                           $time, want.pos, got.pos);
               end
               if (got.data !== want.data) begin
                  error_count++;
                  $display("%0t cell_data mismatch: expected %h actual %h",
                           $time, want.data, got.data);
               end
            end
         end
         if (csr_valid && csr_ready === 1'b1) begin
            if (csr_index == REG_FOREGROUND) shadow_fg = csr_data;
            else if (csr_index == REG_BACKGROUND) shadow_bg = csr_data;
         end
         if (start && busy === 1'b0) begin
            want = apply_console_cmd(req_func, req_char_code, req_cell_index);
            if (pin_valid) want = '{pos: pin_pos, data: pin_data};
            pending_cursor_cells.push_back(want);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == TIMEOUT_CYCLES) begin
         $display("%0t timeout with %0d replies pending", $time, pending_cursor_cells.size());
         $display("tb: done, errors");
         $finish;
      end
   end

   // One command transfer, then maybe a short idle burst
   task automatic send_cmd(input logic [FUNC_W-1:0] f, input logic [CODE_W-1:0] c,
                           input logic [INDEX_W-1:0] idx, input logic pinned,
                           input logic [POS_W-1:0] pos, input logic [DATA_W-1:0] data);
      start          <= 1'b1;
      req_func       <= f;
      req_char_code  <= c;
      req_cell_index <= idx;
      pin_valid      <= pinned;
      pin_pos        <= pos;
      pin_data       <= data;
      do @(posedge clock); while (busy !== 1'b0);
      cmds_sent++;
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic issue(input logic [FUNC_W-1:0] f, input logic [CODE_W-1:0] c,
                        input logic [INDEX_W-1:0] idx);
      send_cmd(f, c, idx, 1'b0, '0, '0);
   endtask

   task automatic add_step(input logic [FUNC_W-1:0] f, input logic [CODE_W-1:0] c,
                           input logic [INDEX_W-1:0] idx, input logic pinned,
                           input logic [POS_W-1:0] pos, input logic [DATA_W-1:0] data);
      directed_step_type s;
      s = '{func: f, code: c, idx: idx, pinned: pinned, pos: pos, data: data};
      directed_plan.push_back(s);
   endtask

   // Hold off until every reply is in, then let any trailing store pass end
   task automatic settle_results();
      start <= 1'b0;
      while (replies_seen != cmds_sent) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_colours(input logic [COLOUR_W-1:0] fg, input logic [COLOUR_W-1:0] bg);
      csr_valid <= 1'b1;
      csr_index <= REG_FOREGROUND;
      csr_data  <= fg;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_index <= REG_BACKGROUND;
      csr_data  <= bg;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [INDEX_W-1:0] pick_read_index();
      case ($urandom_range(0, 3))
         0:       return INDEX_W'($urandom_range(CELLS - COLUMNS, CELLS - 1));
         1:       return INDEX_W'($urandom_range(0, 2 * COLUMNS - 1));
         2:       return INDEX_W'($urandom_range(0, CELLS - 1));
         default: return INDEX_W'($urandom_range(0, INDEX_MAX));
      endcase
   endfunction

   // One burst of console traffic of a randomly chosen shape
   task automatic random_segment(input bit quiet);
      int unsigned kind;
      int unsigned n;
      int unsigned i;
      idle_enable = !quiet && ($urandom_range(0, 3) != 0);
      if (!quiet && $urandom_range(0, 59) == 0) settle_results();
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
         // text line, sometimes long enough to wrap
         n = ($urandom_range(0, 3) == 0) ? $urandom_range(70, 90) : $urandom_range(0, 12);
         for (i = 0; i < n; i++)
            issue(FUNC_PUT, CODE_W'($urandom_range(PRINT_LO, PRINT_HI)),
                  INDEX_W'($urandom_range(0, INDEX_MAX)));
         if ($urandom_range(0, 3) == 0) issue(FUNC_PUT, CHAR_CR, '0);
         issue(FUNC_PUT, CHAR_LF, INDEX_W'($urandom_range(0, INDEX_MAX)));
      end else if (kind < 55) begin
         n = $urandom_range(1, 6);
         for (i = 0; i < n; i++) issue(FUNC_PUT, CHAR_LF, '0);
      end else if (kind < 70) begin
         // cursor editing mixed with text
         n = $urandom_range(1, 6);
         for (i = 0; i < n; i++) begin
            case ($urandom_range(0, 3))
               0:       issue(FUNC_PUT, CHAR_BS, '0);
               1:       issue(FUNC_PUT, CHAR_TAB, '0);
               2:       issue(FUNC_PUT, CHAR_CR, '0);
               default: issue(FUNC_PUT, CODE_W'($urandom_range(PRINT_LO, PRINT_HI)), '0);
            endcase
         end
      end else if (kind < 84) begin
         n = $urandom_range(1, 4);
         for (i = 0; i < n; i++)
            issue(FUNC_READ, CODE_W'($urandom_range(0, CODE_MAX)), pick_read_index());
      end else if (kind < 97) begin
         // noise: any function, any code, any index
         n = $urandom_range(1, 4);
         for (i = 0; i < n; i++)
            issue(FUNC_W'($urandom_range(0, 3)), CODE_W'($urandom_range(0, CODE_MAX)),
                  INDEX_W'($urandom_range(0, INDEX_MAX)));
      end else begin
         issue(FUNC_CLEAR, CODE_W'($urandom_range(0, CODE_MAX)),
               INDEX_W'($urandom_range(0, INDEX_MAX)));
      end
   endtask

   initial begin : stimulus
      int          p;
      int unsigned phase_start;
      for (int i = 0; i < CELLS; i++) shadow_cells[i] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed rows, reset colours (attribute 0x0F)
      add_step(FUNC_READ,  8'h00, 11'd0,    1'b1, 11'd0,  16'h0000);
      add_step(FUNC_READ,  8'h00, 11'd1999, 1'b1, 11'd0,  16'h0000);
      add_step(FUNC_READ,  8'hFF, 11'd2000, 1'b1, 11'd0,  16'h0000);
      add_step(FUNC_READ,  8'hFF, 11'd2047, 1'b1, 11'd0,  16'h0000);
      add_step(FUNC_PUT,   CHAR_BS, 11'd0,  1'b1, 11'd0,  16'h0000);
      add_step(FUNC_PUT,   PRINT_LO, 11'd0, 1'b1, 11'd1,  16'h0000);
      add_step(FUNC_PUT,   PRINT_HI, 11'd2047, 1'b1, 11'd2, 16'h0000);
      add_step(FUNC_READ,  8'h00, 11'd0,    1'b1, 11'd2,  16'h0F20);
      add_step(FUNC_READ,  8'h00, 11'd1,    1'b1, 11'd2,  16'h0F7F);
      add_step(FUNC_PUT,   CHAR_BS, 11'd0,  1'b1, 11'd1,  16'h0000);
      add_step(FUNC_PUT,   8'h80, 11'd0,    1'b1, 11'd1,  16'h0000);
      add_step(FUNC_PUT,   8'hFF, 11'd0,    1'b1, 11'd1,  16'h0000);
      add_step(FUNC_PUT,   8'h00, 11'd0,    1'b1, 11'd1,  16'h0000);
      add_step(FUNC_PUT,   CHAR_TAB, 11'd0, 1'b0, '0, '0);
      add_step(FUNC_PUT,   CHAR_TAB, 11'd0, 1'b0, '0, '0);
      add_step(FUNC_PUT,   CHAR_CR, 11'd0,  1'b1, 11'd0,  16'h0000);
      add_step(FUNC_PUT,   CHAR_LF, 11'd0,  1'b1, 11'd80, 16'h0000);
      add_step(FUNC_NOP,   8'hFF, 11'd2047, 1'b1, 11'd80, 16'h0000);
      add_step(FUNC_PUT,   8'h41, 11'd0,    1'b1, 11'd81, 16'h0000);
      add_step(FUNC_READ,  8'h00, 11'd80,   1'b1, 11'd81, 16'h0F41);
      add_step(FUNC_READ,  8'h00, 11'd79,   1'b0, '0, '0);
      add_step(FUNC_CLEAR, 8'hFF, 11'd2047, 1'b1, 11'd0,  16'h0000);
      add_step(FUNC_READ,  8'h00, 11'd1999, 1'b1, 11'd0,  16'h0F20);
      add_step(FUNC_READ,  8'h00, 11'd80,   1'b1, 11'd0,  16'h0F20);
      add_step(FUNC_PUT,   CHAR_LF, 11'd0,  1'b0, '0, '0);

      idle_enable = 1'b1;
      foreach (directed_plan[i])
         send_cmd(directed_plan[i].func, directed_plan[i].code, directed_plan[i].idx,
                  directed_plan[i].pinned, directed_plan[i].pos, directed_plan[i].data);
      settle_results();

      // Random phases, each under its own colours; the last one without gaps
      for (p = 0; p < PHASES; p++) begin
         case (p)
            0:       write_colours(4'h0, 4'hF);
            1:       write_colours(4'hF, 4'hF);
            2:       write_colours(4'h0, 4'h0);
            default: write_colours(COLOUR_W'($urandom_range(0, 15)),
                                   COLOUR_W'($urandom_range(0, 15)));
         endcase
         phase_start = cmds_sent;
         while (cmds_sent - phase_start < PHASE_ITEMS) random_segment(p == PHASES - 1);
         settle_results();
      end

      repeat (END_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_cursor_cells.size() == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule

`default_nettype wire
